// File: rtl/core/chr_pkg.sv
package chr_pkg;

	localparam int NUM_CHANNELS_DEF = 16;
	localparam int SAMPLE_BITS_DEF  = 24;
	localparam int CH_W             = 4;
	localparam int RATIO_W          = 29;
	localparam int FRAC_BITS        = 24;
	localparam int PRIME_W          = 2;
	localparam int CNT_W            = 6;

	localparam logic [RATIO_W-1:0] ONE_Q24   = RATIO_W'(32'h0100_0000);
	localparam logic [RATIO_W-1:0] RATIO_MIN = RATIO_W'(32'd262144);
	localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(32'd268435456);
	localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(63);
	localparam logic [PRIME_W-1:0] PRIMED    = PRIME_W'(3);

	typedef enum logic [0:0] {
		REG_RATIO  = 1'b0,
		REG_NUM_CH = 1'b1
	} chr_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_EMIT,
		ST_WB,
		ST_SINGLE
	} chr_state_t;

endpackage

// File: rtl/core/cubic_hermite_resampler_top.sv
// A pass-through or bad-channel sample goes from the input registers through ST_SINGLE to
// the output register. A primed channel's sample reads its table entry and updates it in
// ST_MOD; each result then takes three multiply steps through one shared multiplier. A
// new sample is taken only in ST_IDLE, once the last one is written back or output;
// output stalls hold the flow.
// Reset: ratio 1.0, no channels in use; per-channel flags make every channel read as zero.
module cubic_hermite_resampler_top #(
	parameter int NUM_CHANNELS = chr_pkg::NUM_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = chr_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [chr_pkg::RATIO_W-1:0]     cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [chr_pkg::CH_W-1:0]        channel,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [chr_pkg::CH_W-1:0]        out_channel,
	output logic signed [SAMPLE_BITS-1:0]   out_sample,
	output logic                            last_of_run,
	output logic                            bad_channel
);
	import chr_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CW    = SB + 4;
	localparam int PW    = SB + 6;
	localparam int MW    = PW + FRAC_BITS + 1;
	localparam int WORD_W = PRIME_W + RATIO_W + 4 * SB;
	localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);
	localparam logic signed [MW-1:0] HALF_LSB = MW'(64'sd1 <<< (FRAC_BITS - 1));

	chr_state_t state_q, state_d;

	logic [RATIO_W-1:0] ratio_q;
	logic [4:0]         num_ch_q;

	logic [WORD_W-1:0] mem [NUM_CHANNELS];
	logic [WORD_W-1:0] mem_rd_s1;
	logic [NUM_CHANNELS-1:0] vld_q;
	logic              vld_s1;
	logic [AW-1:0]     rd_addr;
	logic              mem_we;
	logic [WORD_W-1:0] mem_wdata;

	logic [CH_W-1:0]        ch_q;
	logic [AW-1:0]          addr_q;
	logic signed [SB-1:0]   smp_q;
	logic                   bad_q;
	logic signed [SB-1:0]   hp_q, hc_q, hn_q, hn2_q;
	logic [PRIME_W-1:0]     prime_q;
	logic [RATIO_W-1:0]     pos_q;
	logic signed [CW-1:0]   a2_q, b2_q, c2_q;
	logic signed [PW-1:0]   p_q;
	logic [CNT_W-1:0]       n_q;

	logic out_valid_q, out_last_q, out_bad_q;
	logic [CH_W-1:0] out_ch_q;
	logic signed [SB-1:0] out_smp_q;

	logic in_fire, out_load, bad_in, pass_in;
	logic [RATIO_W-1:0] step;
	logic [RATIO_W-1:0] pos_adv;
	logic               last_emit;

	// decoded entry, zero when never written
	logic [WORD_W-1:0]      word;
	logic signed [SB-1:0]   e_prev, e_cur, e_next, e_next2;
	logic [RATIO_W-1:0]     e_pos, pos_sub;
	logic [PRIME_W-1:0]     e_prime;
	logic signed [CW-1:0]   xm1, x0, x1, x2;

	logic signed [PW-1:0] mul_a, addend, rnd, p_next, p_half, sat_v;
	logic signed [MW-1:0] prod;

	assign in_fire = in_valid && in_ready;
	assign rd_addr = AW'(channel);
	assign bad_in  = ({1'b0, channel} >= num_ch_q) || (32'(channel) >= NUM_CHANNELS);
	assign pass_in = (ratio_q == ONE_Q24);

	assign step = (ratio_q < RATIO_MIN) ? RATIO_MIN :
	              (ratio_q > RATIO_MAX) ? RATIO_MAX : ratio_q;
	assign pos_adv   = pos_q + step;
	assign last_emit = (pos_adv >= ONE_Q24) || (n_q == CNT_LAST);

	assign word    = vld_s1 ? mem_rd_s1 : '0;
	assign e_next2 = word[SB-1:0];
	assign e_next  = word[2*SB-1:SB];
	assign e_cur   = word[3*SB-1:2*SB];
	assign e_prev  = word[4*SB-1:3*SB];
	assign e_pos   = word[4*SB+RATIO_W-1:4*SB];
	assign e_prime = word[WORD_W-1:4*SB+RATIO_W];
	assign pos_sub = (e_pos >= ONE_Q24) ? e_pos - ONE_Q24 : '0;

	// history after the shift
	assign xm1 = CW'(e_cur);
	assign x0  = CW'(e_next);
	assign x1  = CW'(e_next2);
	assign x2  = CW'(smp_q);

	assign mem_wdata = {prime_q, pos_q, hp_q, hc_q, hn_q, hn2_q};

	// shared Horner step
	always_comb begin
		mul_a  = p_q;
		addend = PW'(c2_q);
		case (state_q)
			ST_MUL1: begin
				mul_a  = PW'(a2_q);
				addend = PW'(b2_q);
			end
			ST_MUL3: addend = PW'(hc_q) <<< 1;
			default: addend = PW'(c2_q);
		endcase
		prod   = MW'(mul_a) * MW'($signed({1'b0, pos_q[FRAC_BITS-1:0]}));
		rnd    = PW'((prod + HALF_LSB) >>> FRAC_BITS);
		p_next = rnd + addend;
		p_half = (p_q + PW'(1)) >>> 1;
		sat_v  = (p_half > SMAX) ? SMAX : (p_half < SMIN) ? SMIN : p_half;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_fire) state_d = (bad_in || pass_in) ? ST_SINGLE : ST_MOD;
			ST_MOD:    state_d = (e_prime != PRIMED || pos_sub >= ONE_Q24) ? ST_WB : ST_MUL1;
			ST_MUL1:   state_d = ST_MUL2;
			ST_MUL2:   state_d = ST_MUL3;
			ST_MUL3:   state_d = ST_EMIT;
			ST_EMIT:   if (out_load) state_d = last_emit ? ST_WB : ST_MUL1;
			ST_WB:     state_d = ST_IDLE;
			ST_SINGLE: if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_WB:     mem_we = 1'b1;
			ST_EMIT,
			ST_SINGLE: out_load = !out_valid_q || out_ready;
			default:   in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ratio_q     <= ONE_Q24;
			num_ch_q    <= '0;
			vld_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (chr_reg_t'(cfg_index))
					REG_RATIO:  ratio_q <= cfg_wdata;
					REG_NUM_CH: num_ch_q <= cfg_wdata[4:0];
					default:    ratio_q <= ratio_q;
				endcase
			end
			if (in_fire) vld_s1 <= vld_q[rd_addr];
			if (mem_we) vld_q[addr_q] <= 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) mem_rd_s1 <= mem[rd_addr];
		if (mem_we) mem[addr_q] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q   <= channel;
			addr_q <= rd_addr;
			smp_q  <= sample;
			bad_q  <= bad_in;
		end
		case (state_q)
			ST_MOD: begin
				n_q <= '0;
				if (e_prime != PRIMED) begin
					prime_q <= e_prime + PRIME_W'(1);
					hp_q    <= e_prev;
					hc_q    <= e_cur;
					hn_q    <= e_next;
					hn2_q   <= e_next2;
					pos_q   <= e_pos;
					if (e_prime == PRIME_W'(0)) hc_q <= smp_q;
					else if (e_prime == PRIME_W'(1)) hn_q <= smp_q;
					else begin
						hn2_q <= smp_q;
						hp_q  <= '0;
						pos_q <= '0;
					end
				end else begin
					prime_q <= e_prime;
					hp_q    <= e_cur;
					hc_q    <= e_next;
					hn_q    <= e_next2;
					hn2_q   <= smp_q;
					pos_q   <= pos_sub;
					a2_q    <= CW'(3) * (x0 - x1) - xm1 + x2;
					b2_q    <= (x1 <<< 2) + (xm1 <<< 1) - CW'(5) * x0 - x2;
					c2_q    <= x1 - xm1;
				end
			end
			ST_MUL1, ST_MUL2, ST_MUL3: p_q <= p_next;
			ST_EMIT: begin
				if (out_load) begin
					pos_q <= pos_adv;
					n_q   <= n_q + CNT_W'(1);
				end
			end
			default: p_q <= p_q;
		endcase
		if (out_load) begin
			out_ch_q <= ch_q;
			if (state_q == ST_SINGLE) begin
				out_smp_q  <= bad_q ? '0 : smp_q;
				out_last_q <= 1'b1;
				out_bad_q  <= bad_q;
			end else begin
				out_smp_q  <= SB'(sat_v);
				out_last_q <= last_emit;
				out_bad_q  <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_ch_q;
	assign out_sample  = out_smp_q;
	assign last_of_run = out_last_q;
	assign bad_channel = out_bad_q;

	a_wb_only: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_WB))
		else $error("table written outside writeback");
	a_fire_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_MOD || state_q == ST_SINGLE))
		else $error("bad state after input transfer");
	a_pos_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL1) |-> (pos_q < ONE_Q24))
		else $error("interpolating at position of one or more");
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SINGLE && out_load) |=> (out_valid_q && out_last_q))
		else $error("single result not marked last");
endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
	import chr_pkg::*;

	localparam int SW = SAMPLE_BITS_DEF;
	localparam int NCH = NUM_CHANNELS_DEF;
	localparam logic [RATIO_W-1:0] ONE = ONE_Q24;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic signed [SW-1:0] smp;
	} sample_item_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic signed [SW-1:0] smp;
		logic last;
		logic bad;
	} resampled_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [RATIO_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [CH_W-1:0] channel;
	logic signed [SW-1:0] sample;
	logic out_valid;
	logic out_ready;
	logic [CH_W-1:0] out_channel;
	logic signed [SW-1:0] out_sample;
	logic last_of_run;
	logic bad_channel;

	cubic_hermite_resampler_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .channel(channel), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready), .out_channel(out_channel),
		.out_sample(out_sample), .last_of_run(last_of_run), .bad_channel(bad_channel)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// shadow of the resampler's per-channel state and registers
	longint hist_p[NCH], hist_c[NCH], hist_n[NCH], hist_n2[NCH];
	longint unsigned pos_q24[NCH];
	int prime_cnt[NCH];
	logic [RATIO_W-1:0] ratio_q24;
	int chans_used;

	sample_item_t pending_q[$];
	resampled_t expected_q[$];
	int idle_pct;
	int stall_pct;
	int mismatches;

	function automatic longint rnd_shift(longint x, int k);
		longint y;
		y = x + (longint'(1) <<< (k - 1));
		if (y >= 0)
			return y >>> k;
		return -(((-y) + ((longint'(1) <<< k) - 1)) >>> k);
	endfunction

	function automatic longint clip_sample(longint v);
		longint hi;
		hi = (longint'(1) <<< (SW - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	task automatic resample_item(sample_item_t it);
		resampled_t r;
		int c;
		int n;
		longint s, a2, b2, c2, p, t;
		longint unsigned pos, step;
		c = it.ch;
		s = it.smp;
		r.ch = it.ch;
		r.bad = 1'b0;
		r.last = 1'b1;
		if (c >= chans_used || c >= NCH) begin
			r.smp = '0;
			r.bad = 1'b1;
			expected_q.push_back(r);
			return;
		end
		if (ratio_q24 == ONE) begin
			r.smp = it.smp;
			expected_q.push_back(r);
			return;
		end
		if (prime_cnt[c] < 3) begin
			if (prime_cnt[c] == 0)
				hist_c[c] = s;
			else if (prime_cnt[c] == 1)
				hist_n[c] = s;
			else begin
				hist_n2[c] = s;
				hist_p[c] = 0;
				pos_q24[c] = 0;
			end
			prime_cnt[c]++;
			return;
		end
		hist_p[c] = hist_c[c];
		hist_c[c] = hist_n[c];
		hist_n[c] = hist_n2[c];
		hist_n2[c] = s;
		pos = pos_q24[c];
		pos = (pos >= ONE) ? pos - ONE : 0;
		step = ratio_q24;
		if (step < RATIO_MIN)
			step = RATIO_MIN;
		if (step > RATIO_MAX)
			step = RATIO_MAX;
		a2 = 3 * (hist_c[c] - hist_n[c]) - hist_p[c] + hist_n2[c];
		b2 = 4 * hist_n[c] + 2 * hist_p[c] - 5 * hist_c[c] - hist_n2[c];
		c2 = hist_n[c] - hist_p[c];
		n = 0;
		while (pos < ONE && n < 64) begin
			t = longint'(pos);
			p = rnd_shift(a2 * t, 24) + b2;
			p = rnd_shift(p * t, 24) + c2;
			p = rnd_shift(p * t, 24) + 2 * hist_c[c];
			r.smp = SW'(clip_sample(rnd_shift(p, 1)));
			r.last = 1'b0;
			expected_q.push_back(r);
			n++;
			pos += step;
		end
		pos_q24[c] = pos & 29'h1FFF_FFFF;
		if (n > 0)
			expected_q[expected_q.size() - 1].last = 1'b1;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			channel <= '0;
			sample <= '0;
		end else begin
			if (in_valid && in_ready) begin
				resample_item('{channel, sample});
				void'(pending_q.pop_front());
			end
			if (!in_valid || in_ready) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					in_valid <= 1'b1;
					channel <= pending_q[0].ch;
					sample <= pending_q[0].smp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer ch=%0d smp=%0d", out_channel, out_sample);
				end else begin
					resampled_t e;
					e = expected_q.pop_front();
					if (e.ch !== out_channel || e.smp !== out_sample
							|| e.last !== last_of_run || e.bad !== bad_channel) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch exp ch=%0d smp=%0d last=%0b bad=%0b",
								" got ch=%0d smp=%0d last=%0b bad=%0b"},
								e.ch, e.smp, e.last, e.bad,
								out_channel, out_sample, last_of_run, bad_channel);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic write_reg(chr_reg_t idx, logic [RATIO_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RATIO)
			ratio_q24 = val;
		else
			chans_used = val[4:0];
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || in_valid || expected_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic signed [SW-1:0] rnd_smp();
		case ($urandom_range(4))
			0: return {1'b0, {(SW-1){1'b1}}};
			1: return {1'b1, {(SW-1){1'b0}}};
			2: return SW'($urandom_range(2000)) - SW'(1000);
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic queue_item(int ch, logic signed [SW-1:0] v);
		pending_q.push_back('{CH_W'(ch), v});
	endtask

	task automatic run_phase(logic [RATIO_W-1:0] rat, int nch, int count);
		write_reg(REG_RATIO, rat);
		write_reg(REG_NUM_CH, RATIO_W'(nch));
		for (int i = 0; i < count; i++) begin
			int ch;
			ch = ($urandom_range(9) == 0) ? $urandom_range(15)
				: $urandom_range((nch > 0 ? nch : 1) - 1);
			queue_item(ch, rnd_smp());
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RATIO;
		cfg_wdata = '0;
		mismatches = 0;
		idle_pct = 0;
		stall_pct = 0;
		for (int c = 0; c < NCH; c++) begin
			hist_p[c] = 0; hist_c[c] = 0; hist_n[c] = 0; hist_n2[c] = 0;
			pos_q24[c] = 0; prime_cnt[c] = 0;
		end
		ratio_q24 = ONE;
		chans_used = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// all channels rejected at reset, then pass-through extremes
		queue_item(0, 24'sh7FFFFF);
		queue_item(15, 24'sh800000);
		drain();
		write_reg(REG_NUM_CH, 29'd16);
		queue_item(15, 24'sh7FFFFF);
		queue_item(0, 24'sh800000);
		queue_item(3, 24'sh000000);
		drain();
		// priming, full-scale swings to force saturation, lowest ratio
		write_reg(REG_RATIO, 29'd262144);
		write_reg(REG_NUM_CH, 29'd2);
		queue_item(0, 24'sh7FFFFF);
		queue_item(0, 24'sh800000);
		queue_item(0, 24'sh7FFFFF);
		queue_item(0, 24'sh800000);
		queue_item(1, 24'sh000001);
		queue_item(2, 24'sh123456);
		drain();
		// ratio clamped below and above, position stepping by more than one
		write_reg(REG_RATIO, 29'd1);
		queue_item(0, 24'sh7FFFFF);
		drain();
		write_reg(REG_RATIO, 29'h1FFF_FFFF);
		for (int i = 0; i < 6; i++)
			queue_item(1, (i % 2) ? 24'sh800000 : 24'sh7FFFFF);
		drain();
		idle_pct = 0; stall_pct = 0;
		run_phase(29'd20000000, 4, 60);
		idle_pct = 86; stall_pct = 0;
		run_phase(29'd8000000, 16, 60);
		idle_pct = 0; stall_pct = 86;
		run_phase(29'd268435456, 8, 50);
		idle_pct = 31; stall_pct = 31;
		run_phase(29'd13000000, 3, 60);
		idle_pct = 31; stall_pct = 31;
		run_phase(ONE, 5, 20);
		if (mismatches == 0)
			$display("cubic_hermite_resampler_top regression: pass");
		else
			$display("cubic_hermite_resampler_top regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("cubic_hermite_resampler_top regression: fail");
		$finish;
	end
endmodule
